FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
// Needs nothing else; each macro takes a label, the clock and the reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

FILE: design/grc_pkg.sv
// Package for the grid ray caster: constants, codes and the sequencer state type.
// Depends on nothing.
`timescale 1ns / 1ps
package grc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAP_DIM     = 64;
  localparam int GRID_DEPTH  = 4096;
  localparam int GRID_AW     = 12;
  localparam int SCREEN_ROWS = 480;
  localparam int STEP_LIMIT  = 2 * MAP_DIM + 2;
  localparam int DIV_N       = 40;
  localparam int DEN_W       = 24;
  localparam int MA_W        = 29;
  localparam int MB_W        = 25;
  localparam int PROD_W      = MA_W + MB_W;
  localparam int RAY_W       = 21;
  localparam int DELTA_W     = 28;
  localparam int SIDE_W      = 38;
  localparam int PERP_W      = 24;
  localparam int NUM_W       = 26;

  // Request codes.
  localparam logic REQ_MAP  = 1'b0;
  localparam logic REQ_CAST = 1'b1;

  typedef enum logic [2:0] {
    FACE_WEST  = 3'd0,
    FACE_EAST  = 3'd1,
    FACE_NORTH = 3'd2,
    FACE_SOUTH = 3'd3,
    FACE_NONE  = 3'd4
  } face_t;

  typedef enum logic [2:0] {
    REG_PLAYER_X, REG_PLAYER_Y, REG_DIR_X, REG_DIR_Y,
    REG_PLANE_X, REG_PLANE_Y, REG_MAP_COLS, REG_MAP_ROWS
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MULX, S_MULY, S_RAYY, S_DX, S_DY, S_MSX, S_MSY, S_SDY,
    S_STEP, S_LOOK, S_TEST, S_DP, S_MT, S_TU, S_DL, S_OUT
  } state_t;

endpackage

FILE: design/grid_ray_caster_dda_top.sv
// Top level of the grid ray caster: register file, wall grid memory and cast sequencer.
// Depends on grc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Grid ray caster. After reset the block runs a clearing pass over the 4096-cell wall
// grid, one cell a cycle, holding busy high until the pass ends. A map write returns
// nothing. A cast runs on one shared 29 x 25 multiplier and one shared restoring
// divider (one quotient bit a cycle, with a load step first): five multiplies, up to
// four divisions and, for each grid step, the step, look and test states. done is
// high for exactly one cycle when the result is ready; it cannot be held. The result
// ports keep their values until the next request is accepted.
module grid_ray_caster_dda_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type,
  input  logic [5:0]            cell_col,
  input  logic [5:0]            cell_row,
  input  logic                  cell_is_wall,
  input  logic signed [17:0]    camera_x,
  output logic                  done,
  output logic                  hit,
  output logic [2:0]            wall_face,
  output logic [23:0]           perp_dist,
  output logic [15:0]           tex_u,
  output logic [15:0]           line_height,
  input  logic                  cfg_wr,
  input  logic [2:0]            cfg_index,
  input  logic [21:0]           cfg_data
);
  import grc_pkg::*;

  state_t state, state_next;

  logic [21:0]        player_x, player_y;
  logic [17:0]        dir_x, dir_y, plane_x, plane_y;
  logic [6:0]         map_cols, map_rows, cols, rows;

  logic [17:0]        cam;
  logic [RAY_W-1:0]   ray_x, ray_y;
  logic [DELTA_W-1:0] dx, dy;
  logic [SIDE_W-1:0]  sdx, sdy;
  logic [7:0]         mx, my, n;
  logic               side, res_hit;
  logic [PERP_W-1:0]  perp;
  logic [15:0]        tex, line;

  logic               grid [0:GRID_DEPTH-1];
  logic               grid_rd;
  logic [GRID_AW-1:0] clr_cnt;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      player_x <= '0;
      player_y <= '0;
      dir_x    <= 18'd65536;
      dir_y    <= '0;
      plane_x  <= '0;
      plane_y  <= 18'd43254;
      map_cols <= 7'd64;
      map_rows <= 7'd64;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PLAYER_X: player_x <= cfg_data;
        REG_PLAYER_Y: player_y <= cfg_data;
        REG_DIR_X:    dir_x    <= cfg_data[17:0];
        REG_DIR_Y:    dir_y    <= cfg_data[17:0];
        REG_PLANE_X:  plane_x  <= cfg_data[17:0];
        REG_PLANE_Y:  plane_y  <= cfg_data[17:0];
        REG_MAP_COLS: map_cols <= cfg_data[6:0];
        REG_MAP_ROWS: map_rows <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign cols = (map_cols > 7'(MAP_DIM)) ? 7'(MAP_DIM) : map_cols;
  assign rows = (map_rows > 7'(MAP_DIM)) ? 7'(MAP_DIM) : map_rows;

  // Wall grid memory: clearing pass or map writes, registered read of the current cell.
  logic               mem_we, mem_wdata;
  logic [GRID_AW-1:0] mem_waddr, rd_addr;
  logic               accept;

  assign accept    = start && !busy;
  assign mem_we    = (state == S_CLEAR) || (accept && req_type == REQ_MAP);
  assign mem_waddr = (state == S_CLEAR) ? clr_cnt : {cell_row, cell_col};
  assign mem_wdata = (state == S_CLEAR) ? 1'b0 : cell_is_wall;
  assign rd_addr   = {my[5:0], mx[5:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid[mem_waddr] <= mem_wdata;
    end
    grid_rd <= grid[rd_addr];
  end

  // Shared multiplier with a registered product.
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [16:0]              fx_term, fy_term;

  assign fx_term = ray_x[RAY_W-1] ? {1'b0, player_x[15:0]} : 17'h10000 - {1'b0, player_x[15:0]};
  assign fy_term = ray_y[RAY_W-1] ? {1'b0, player_y[15:0]} : 17'h10000 - {1'b0, player_y[15:0]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MULX: begin
        mul_a = {{(MA_W-18){plane_x[17]}}, plane_x};
        mul_b = {{(MB_W-18){cam[17]}}, cam};
      end
      S_MULY: begin
        mul_a = {{(MA_W-18){plane_y[17]}}, plane_y};
        mul_b = {{(MB_W-18){cam[17]}}, cam};
      end
      S_MSX: begin
        mul_a = {1'b0, dx};
        mul_b = {{(MB_W-17){1'b0}}, fx_term};
      end
      S_MSY: begin
        mul_a = {1'b0, dy};
        mul_b = {{(MB_W-17){1'b0}}, fy_term};
      end
      S_MT: begin
        mul_a = side ? {{(MA_W-RAY_W){ray_x[RAY_W-1]}}, ray_x}
                     : {{(MA_W-RAY_W){ray_y[RAY_W-1]}}, ray_y};
        mul_b = {1'b0, perp};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Perpendicular distance numerator for the side that was hit.
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  num_abs;
  logic [RAY_W-1:0]  ray_s, ray_abs_x, ray_abs_y, ray_abs_s;
  logic              num_neg, num_zero, ray_s_neg, opposite;

  always_comb begin
    if (!side) begin
      num = {{2{mx[7]}}, mx, 16'h0000} - {4'b0, player_x}
            + (ray_x[RAY_W-1] ? 26'h10000 : 26'h0);
    end else begin
      num = {{2{my[7]}}, my, 16'h0000} - {4'b0, player_y}
            + (ray_y[RAY_W-1] ? 26'h10000 : 26'h0);
    end
  end

  assign num_neg   = num[NUM_W-1];
  assign num_zero  = (num == '0);
  assign num_abs   = num_neg ? -num : num;
  assign ray_s     = side ? ray_y : ray_x;
  assign ray_s_neg = ray_s[RAY_W-1];
  assign ray_abs_x = ray_x[RAY_W-1] ? -ray_x : ray_x;
  assign ray_abs_y = ray_y[RAY_W-1] ? -ray_y : ray_y;
  assign ray_abs_s = side ? ray_abs_y : ray_abs_x;
  assign opposite  = (!num_neg && !num_zero && ray_s_neg) ||
                     (num_neg && !ray_s_neg && ray_s != '0);

  // Shared restoring divider, one quotient bit a cycle.
  logic [DIV_N-1:0] div_quo, div_quo_step, div_num_in;
  logic [DEN_W-1:0] div_rem, div_den, div_den_in, div_rem_step;
  logic [DEN_W:0]   div_rem_sh;
  logic [5:0]       div_cnt;
  logic             div_run, div_ge, div_done, div_state, div_skip;

  assign div_rem_sh   = {div_rem, div_quo[DIV_N-1]};
  assign div_ge       = div_rem_sh >= {1'b0, div_den};
  assign div_rem_step = div_ge ? DEN_W'(div_rem_sh - {1'b0, div_den}) : div_rem_sh[DEN_W-1:0];
  assign div_quo_step = {div_quo[DIV_N-2:0], div_ge};
  assign div_done     = div_run && (div_cnt == 6'(DIV_N - 1));
  assign div_state    = (state == S_DX) || (state == S_DY) || (state == S_DP) || (state == S_DL);

  always_comb begin
    div_num_in = '0;
    div_den_in = '0;
    div_skip   = 1'b0;
    unique case (state)
      S_DX: begin
        div_num_in = DIV_N'(64'h1_0000_0000);
        div_den_in = {3'b0, ray_abs_x};
        div_skip   = (ray_x == '0);
      end
      S_DY: begin
        div_num_in = DIV_N'(64'h1_0000_0000);
        div_den_in = {3'b0, ray_abs_y};
        div_skip   = (ray_y == '0);
      end
      S_DP: begin
        div_num_in = {num_abs[PERP_W-1:0], 16'h0000};
        div_den_in = {3'b0, ray_abs_s};
        div_skip   = (ray_s == '0) || opposite;
      end
      S_DL: begin
        div_num_in = DIV_N'(SCREEN_ROWS) << FRAC_BITS;
        div_den_in = perp;
        div_skip   = (perp == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
      div_cnt <= '0;
    end else if (div_state && !div_skip) begin
      if (!div_run) begin
        div_run <= 1'b1;
        div_cnt <= '0;
        div_quo <= div_num_in;
        div_rem <= '0;
        div_den <= div_den_in;
      end else begin
        div_run <= !div_done;
        div_cnt <= div_cnt + 6'd1;
        div_quo <= div_quo_step;
        div_rem <= div_rem_step;
      end
    end
  end

  // Bounds check on the current cell.
  logic oob;
  assign oob = mx[7] || ({1'b0, mx} >= {2'b0, cols}) ||
               my[7] || ({1'b0, my} >= {2'b0, rows});

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == GRID_AW'(GRID_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (start && req_type == REQ_CAST) state_next = S_MULX;
      S_MULX:  state_next = S_MULY;
      S_MULY:  state_next = S_RAYY;
      S_RAYY:  state_next = S_DX;
      S_DX:    if (div_skip || div_done) state_next = S_DY;
      S_DY:    if (div_skip || div_done) state_next = S_MSX;
      S_MSX:   state_next = S_MSY;
      S_MSY:   state_next = S_SDY;
      S_SDY:   state_next = S_STEP;
      S_STEP:  state_next = S_LOOK;
      S_LOOK:  state_next = oob ? S_OUT : S_TEST;
      S_TEST: begin
        if (grid_rd) begin
          state_next = S_DP;
        end else if (n == 8'(STEP_LIMIT)) begin
          state_next = S_OUT;
        end else begin
          state_next = S_STEP;
        end
      end
      S_DP:    if (div_skip || div_done) state_next = S_MT;
      S_MT:    state_next = S_TU;
      S_TU:    state_next = S_DL;
      S_DL:    if (div_skip || div_done) state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Cast datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      res_hit <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: clr_cnt <= clr_cnt + GRID_AW'(1);
        S_IDLE: begin
          if (accept) begin
            cam     <= camera_x;
            res_hit <= 1'b0;
          end
        end
        S_MULY: ray_x <= {{3{dir_x[17]}}, dir_x} + prod[RAY_W+FRAC_BITS-1:FRAC_BITS];
        S_RAYY: ray_y <= {{3{dir_y[17]}}, dir_y} + prod[RAY_W+FRAC_BITS-1:FRAC_BITS];
        S_DX: begin
          if (div_skip || (div_done && |div_quo_step[DIV_N-1:DELTA_W])) begin
            dx <= '1;
          end else if (div_done) begin
            dx <= div_quo_step[DELTA_W-1:0];
          end
        end
        S_DY: begin
          if (div_skip || (div_done && |div_quo_step[DIV_N-1:DELTA_W])) begin
            dy <= '1;
          end else if (div_done) begin
            dy <= div_quo_step[DELTA_W-1:0];
          end
        end
        S_MSY: sdx <= {9'b0, prod[DELTA_W+1+FRAC_BITS-1:FRAC_BITS]};
        S_SDY: begin
          sdy <= {9'b0, prod[DELTA_W+1+FRAC_BITS-1:FRAC_BITS]};
          mx  <= {2'b0, player_x[21:16]};
          my  <= {2'b0, player_y[21:16]};
          n   <= '0;
        end
        S_STEP: begin
          n <= n + 8'd1;
          if (sdx < sdy) begin
            sdx  <= sdx + {10'b0, dx};
            mx   <= ray_x[RAY_W-1] ? mx - 8'd1 : mx + 8'd1;
            side <= 1'b0;
          end else begin
            sdy  <= sdy + {10'b0, dy};
            my   <= ray_y[RAY_W-1] ? my - 8'd1 : my + 8'd1;
            side <= 1'b1;
          end
        end
        S_TEST: if (grid_rd) res_hit <= 1'b1;
        S_DP: begin
          if (ray_s == '0) begin
            perp <= '1;
          end else if (opposite) begin
            perp <= '0;
          end else if (div_done) begin
            perp <= |div_quo_step[DIV_N-1:PERP_W] ? '1 : div_quo_step[PERP_W-1:0];
          end
        end
        S_TU: tex <= prod[31:16] + (side ? player_x[15:0] : player_y[15:0]);
        S_DL: begin
          if (div_skip || (div_done && |div_quo_step[DIV_N-1:16])) begin
            line <= '1;
          end else if (div_done) begin
            line <= div_quo_step[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Result ports.
  face_t face;
  always_comb begin
    if (!res_hit) begin
      face = FACE_NONE;
    end else if (!side) begin
      face = ray_x[RAY_W-1] ? FACE_WEST : FACE_EAST;
    end else begin
      face = ray_y[RAY_W-1] ? FACE_NORTH : FACE_SOUTH;
    end
  end

  assign busy        = (state != S_IDLE);
  assign done        = (state == S_OUT);
  assign hit         = res_hit;
  assign wall_face   = face;
  assign perp_dist   = res_hit ? perp : '0;
  assign tex_u       = res_hit ? tex : '0;
  assign line_height = res_hit ? line : '0;

  // Checks on the sequencer.
  `ASSERT_IMP(a_done_busy, clk, rst, done, busy)
  `ASSERT_NXT(a_done_once, clk, rst, done, !done)
  `ASSERT_IMP(a_miss_vals, clk, rst, done && !hit, wall_face == FACE_NONE && perp_dist == '0)
  `ASSERT_IMP(a_div_idle, clk, rst, div_run, div_state)

endmodule
